/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, ante, cons, rstn) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/dbpc_pkg.sv */
// Package: types and constants of the dual button press counter.
`timescale 1ns / 1ps

package dbpc_pkg;

    localparam int TIME_WIDTH     = 32;
    localparam int COUNT_WIDTH    = 16;
    localparam int CFG_WIDTH      = 16;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_INDEX_BIT  = 2;

    localparam logic REG_SAMPLE_INTERVAL = 1'b0;
    localparam logic REG_LONG_PRESS      = 1'b1;

    localparam logic [CFG_WIDTH-1:0] SAMPLE_INTERVAL_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET      = 16'd1000;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] now_ms;
        logic                  green_level;
        logic                  red_level;
    } in_item_t;

    typedef struct packed {
        logic                   sampled;
        logic                   green_short;
        logic                   red_short;
        logic                   green_long;
        logic                   red_long;
        logic [TIME_WIDTH-1:0]  press_duration;
        logic [COUNT_WIDTH-1:0] press_count;
    } out_item_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] sample_interval_ms;
        logic [CFG_WIDTH-1:0] long_press_ms;
    } cfg_t;

endpackage

/* rtl/dual_button_press_counter_unit.sv */
// An accepted word is held in the input register, then moves to the result register
// (m_data) once that is empty or drained. Throughput: one word per cycle while m_ready
// allows; the two registers run as a two-stage pipe, rate set by dbpc_core's update.
// Reset: synchronous, active low; clears both valid flags and all press state, and
// loads the interval and threshold registers with 50 ms and 1000 ms.
`timescale 1ns / 1ps

module dual_button_press_counter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dbpc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dbpc_pkg::out_item_t                 m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dbpc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [dbpc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [dbpc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready
);
    import dbpc_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    out_item_t core_result;
    logic      out_valid_reg;
    logic      advance;

    // move a word into the result register when it is empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    dbpc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

endmodule

/* rtl/dbpc_cfg_regs.sv */
// APB configuration registers: sample interval and long-press threshold.
`timescale 1ns / 1ps

module dbpc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dbpc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [dbpc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [dbpc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready,
    output dbpc_pkg::cfg_t                      cfg
);
    import dbpc_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[REG_INDEX_BIT];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_interval_ms <= SAMPLE_INTERVAL_RESET;
            cfg_reg.long_press_ms      <= LONG_PRESS_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_SAMPLE_INTERVAL: cfg_reg.sample_interval_ms <= pwdata[CFG_WIDTH-1:0];
                REG_LONG_PRESS:      cfg_reg.long_press_ms      <= pwdata[CFG_WIDTH-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SAMPLE_INTERVAL: prdata = APB_DATA_WIDTH'(cfg_reg.sample_interval_ms);
            REG_LONG_PRESS:      prdata = APB_DATA_WIDTH'(cfg_reg.long_press_ms);
        endcase
    end

endmodule

/* rtl/dbpc_core.sv */
// Press state and the single-pass update for one button sample.
`timescale 1ns / 1ps

module dbpc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  dbpc_pkg::in_item_t  item,
    input  dbpc_pkg::cfg_t      cfg,
    output dbpc_pkg::out_item_t result
);
    import dbpc_pkg::*;

    logic [TIME_WIDTH-1:0]  last_sample_reg, last_sample_next;
    logic [TIME_WIDTH-1:0]  press_start_reg, press_start_next;
    logic [TIME_WIDTH-1:0]  duration_reg, duration_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next, count_mid;
    logic                   green_prev_reg, green_prev_next;
    logic                   red_prev_reg, red_prev_next;
    logic                   green_long_reg, green_long_next;
    logic                   red_long_reg, red_long_next;

    logic [TIME_WIDTH-1:0]  gap;
    logic [TIME_WIDTH-1:0]  interval;
    logic [TIME_WIDTH-1:0]  threshold;
    logic                   sampled;
    logic                   green_short;
    logic                   red_short;

    assign interval  = TIME_WIDTH'(cfg.sample_interval_ms);
    assign threshold = TIME_WIDTH'(cfg.long_press_ms);
    assign gap       = item.now_ms - last_sample_reg;

    always_comb begin
        last_sample_next = last_sample_reg;
        press_start_next = press_start_reg;
        duration_next    = duration_reg;
        green_prev_next  = green_prev_reg;
        red_prev_next    = red_prev_reg;
        green_long_next  = green_long_reg;
        red_long_next    = red_long_reg;
        count_mid        = count_reg;
        count_next       = count_reg;
        sampled          = 1'b0;
        green_short      = 1'b0;
        red_short        = 1'b0;

        if (gap > interval) begin
            sampled = 1'b1;

            // both buttons share one press timer
            if (item.red_level && !red_prev_reg && !red_long_reg) begin
                press_start_next = item.now_ms;
                red_prev_next    = 1'b1;
            end
            if (item.green_level && !green_prev_reg && !green_long_reg) begin
                press_start_next = item.now_ms;
                green_prev_next  = 1'b1;
            end

            duration_next = item.now_ms - press_start_next;

            if (item.green_level && !green_long_reg && duration_next >= threshold) begin
                green_long_next = 1'b1;
            end
            if (item.red_level && !red_long_reg && duration_next >= threshold) begin
                red_long_next = 1'b1;
            end

            // green counts up first, then red counts down
            if (!item.green_level && green_prev_reg) begin
                green_prev_next = 1'b0;
                green_long_next = 1'b0;
                if (duration_next < threshold) begin
                    green_short = 1'b1;
                    if (count_reg != '1) begin
                        count_mid = count_reg + 1'b1;
                    end
                end
            end
            count_next = count_mid;
            if (!item.red_level && red_prev_reg) begin
                red_prev_next = 1'b0;
                red_long_next = 1'b0;
                if (duration_next < threshold) begin
                    red_short = 1'b1;
                    if (count_mid != '0) begin
                        count_next = count_mid - 1'b1;
                    end
                end
            end

            last_sample_next = item.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg <= '0;
            press_start_reg <= '0;
            duration_reg    <= '0;
            count_reg       <= '0;
            green_prev_reg  <= 1'b0;
            red_prev_reg    <= 1'b0;
            green_long_reg  <= 1'b0;
            red_long_reg    <= 1'b0;
        end else if (step) begin
            last_sample_reg <= last_sample_next;
            press_start_reg <= press_start_next;
            duration_reg    <= duration_next;
            count_reg       <= count_next;
            green_prev_reg  <= green_prev_next;
            red_prev_reg    <= red_prev_next;
            green_long_reg  <= green_long_next;
            red_long_reg    <= red_long_next;
        end
    end

    always_comb begin
        result.sampled        = sampled;
        result.green_short    = green_short;
        result.red_short      = red_short;
        result.green_long     = green_long_next;
        result.red_long       = red_long_next;
        result.press_duration = duration_next;
        result.press_count    = count_next;
    end

endmodule

/* rtl/dbpc_checker.sv */
// Port-level checker for the dual button press counter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dbpc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input dbpc_pkg::out_item_t m_data
);

    logic any_short;
    logic short_and_long;

    assign any_short      = m_data.green_short || m_data.red_short;
    assign short_and_long = (m_data.green_short && m_data.green_long) ||
                            (m_data.red_short && m_data.red_long);

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, aclk, m_valid && !m_ready, $stable(m_data), aresetn)

    // reset leaves no result word pending
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // a skipped sample carries no short press
    `ASSERT_IMPLY(a_no_pulse_unsampled, aclk, aresetn, m_valid && !m_data.sampled, !any_short)

    // a short release also clears that button's long flag
    `ASSERT_IMPLY(a_short_not_long, aclk, aresetn, m_valid && any_short, !short_and_long)

endmodule

bind dual_button_press_counter_unit dbpc_checker u_dbpc_checker (.*);
